>>> rtl/core/ttoe_pkg.sv
// ----------------------------------------------------------------------------
// ttoe_pkg
// Types and codes shared by the threshold trigger output engine.
// ----------------------------------------------------------------------------
package ttoe_pkg;

   localparam logic [1:0] CMD_STORE = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_EVAL  = 2'd2;
   localparam logic [1:0] CMD_FORCE = 2'd3;

   localparam logic [7:0] OPER_NONE  = 8'd0;
   localparam logic [7:0] OPER_BAND  = 8'd1;
   localparam logic [7:0] OPER_BELOW = 8'd2;
   localparam logic [7:0] OPER_ABOVE = 8'd3;
   localparam logic [7:0] OPER_OFF   = 8'd255;

   localparam logic [31:0] HOLD_UNIT = 32'd100;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [7:0]         slot;
      logic signed [15:0] value;
      logic [7:0]         source_sel;
      logic [7:0]         oper_code;
      logic [7:0]         out_index;
      logic               out_polarity;
      logic signed [15:0] band;
      logic [31:0]        now_ms;
      logic               level;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [4:0]  output_bits;
      logic [15:0] event_mask;
   } rsp_type;

   typedef struct packed {
      logic [7:0]         source;
      logic [7:0]         oper;
      logic [7:0]         out;
      logic               polarity;
      logic signed [15:0] threshold;
      logic signed [15:0] band;
   } entry_type;

   typedef struct packed {
      logic        swon;
      logic [31:0] stime;
   } timing_type;

   typedef struct packed {
      entry_type  entry;
      timing_type timing;
   } trig_word_type;

   typedef struct packed {
      logic       fire;
      timing_type timing;
   } act_type;

endpackage

>>> rtl/core/ttoe_ram.sv
// ----------------------------------------------------------------------------
// ttoe_ram
// Single write, single read RAM, registered read; unwritten entries read zero.
// ----------------------------------------------------------------------------
module ttoe_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [AW-1:0]    rd_addr,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rdata_ff;
   logic             rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= valid_ff[rd_addr];
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

>>> rtl/core/ttoe_eval.sv
// ----------------------------------------------------------------------------
// ttoe_eval
// Rule selection and output drive for one trigger during an evaluate pass.
// ----------------------------------------------------------------------------
module ttoe_eval #(
   parameter int NUM_READINGS = 16,
   parameter int NUM_OUTPUTS  = 5
) (
   input  ttoe_pkg::trig_word_type word,
   input  logic signed [15:0]      reading,
   input  logic [31:0]             hold,
   input  logic [31:0]             lock,
   input  logic [31:0]             now_ms,
   input  logic [NUM_OUTPUTS-1:0]  out_cur,
   output ttoe_pkg::act_type       act,
   output logic [NUM_OUTPUTS-1:0]  out_next
);

   logic               active, tnz, off_hold, on_eq, off_eq, on_gt, on_lt, clr;
   logic               do_drive, on, oor, tgt, cur, blocked, sw;
   logic [31:0]        el;
   logic signed [17:0] thr, rd, bd;

   always_comb begin
      active = (word.entry.oper != ttoe_pkg::OPER_NONE) &&
               (word.entry.oper != ttoe_pkg::OPER_OFF) &&
               ({1'b0, word.entry.source} < 9'(NUM_READINGS));
      thr = 18'(word.entry.threshold);
      rd  = 18'(reading);
      bd  = 18'(word.entry.band);
      el  = now_ms - word.timing.stime;
      tnz = word.timing.stime != 32'd0;

      off_hold = word.timing.swon && tnz && (el > hold);
      on_eq  = (word.entry.oper == ttoe_pkg::OPER_BAND) && (thr <= rd - bd);
      off_eq = (word.entry.oper == ttoe_pkg::OPER_BAND) && (thr >= rd + bd);
      on_gt  = (word.entry.oper == ttoe_pkg::OPER_ABOVE) && (thr < rd);
      on_lt  = (word.entry.oper == ttoe_pkg::OPER_BELOW) && (thr > rd);
      clr    = !word.timing.swon && tnz && (el > lock);

      do_drive = active && (off_hold || on_eq || off_eq || on_gt || on_lt);
      on = !off_hold && (on_eq || !off_eq);

      oor = {1'b0, word.entry.out} >= 9'(NUM_OUTPUTS);
      tgt = on ? word.entry.polarity : !word.entry.polarity;
      cur = 1'b0;
      for (int j = 0; j < NUM_OUTPUTS; j++) begin
         if (8'(j) == word.entry.out) begin
            cur = out_cur[j];
         end
      end
      blocked = !word.timing.swon && on && tnz && (el < lock);
      sw = do_drive && !oor && (cur != tgt) && !blocked;

      act.fire   = do_drive && (oor || sw);
      act.timing = word.timing;
      out_next   = out_cur;
      if (sw) begin
         act.timing.swon = on;
         if ((word.entry.band > 16'sd0) && (word.entry.oper > ttoe_pkg::OPER_BAND)) begin
            act.timing.stime = now_ms;
         end
         for (int j = 0; j < NUM_OUTPUTS; j++) begin
            if (8'(j) == word.entry.out) begin
               out_next[j] = tgt;
            end
         end
      end else if (active && !do_drive && clr) begin
         act.timing.stime = 32'd0;
      end
   end

endmodule

>>> rtl/core/threshold_trigger_output_engine_top.sv
// ----------------------------------------------------------------------------
// threshold_trigger_output_engine_top
// Bank of threshold triggers driving output bits, held in two memories.
// ----------------------------------------------------------------------------
// One command per beat, taken when start is high and busy low; exactly one
// result beat follows on rsp_valid, which the receiver must take as it comes.
// Store reading and force output answer in the next cycle and never raise
// busy. Write trigger entry is a read-modify-write of the trigger memory.
// Evaluate walks the trigger memory in index order; each trigger passes
// through entry read, reading read plus hold/lock products, then decide and
// write back. No clearing pass: valid bits make unwritten entries read as
// zero straight out of reset.
// ----------------------------------------------------------------------------
module threshold_trigger_output_engine_top #(
   parameter int NUM_TRIGGERS = 16,
   parameter int NUM_READINGS = 16,
   parameter int NUM_OUTPUTS  = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ttoe_pkg::req_type req_data,
   output logic              rsp_valid,
   output ttoe_pkg::rsp_type rsp_data
);

   localparam int TIW = (NUM_TRIGGERS > 1) ? $clog2(NUM_TRIGGERS) : 1;
   localparam int RIW = (NUM_READINGS > 1) ? $clog2(NUM_READINGS) : 1;
   localparam logic [TIW-1:0] LAST_IDX = TIW'(NUM_TRIGGERS - 1);
   localparam int WW = $bits(ttoe_pkg::trig_word_type);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_WENT = 5'b00010,
      ST_ENT  = 5'b00100,
      ST_SRC  = 5'b01000,
      ST_ACT  = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [TIW-1:0]          idx_ff, idx_in;
   ttoe_pkg::req_type       req_ff;
   logic [NUM_OUTPUTS-1:0]  out_ff, out_in, out_next;
   logic [15:0]             events_ff, events_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    status_ff, status_in;
   ttoe_pkg::trig_word_type word_ff;
   logic signed [15:0]      rd_ff;
   logic [31:0]             hold_ff, lock_ff, band32;
   ttoe_pkg::act_type       act;

   logic                    accept, wr_ok;
   logic [TIW-1:0]          a_raddr, a_waddr;
   logic                    a_we;
   ttoe_pkg::trig_word_type a_wdata, a_rdata;
   logic [RIW-1:0]          b_raddr;
   logic                    b_we;
   logic [15:0]             b_rdata;
   logic [15:0]             out_wide;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = state_ff != ST_IDLE;
   assign wr_ok  = ({1'b0, req_data.slot} < 9'(NUM_TRIGGERS)) &&
                   ({1'b0, req_data.source_sel} < 9'(NUM_READINGS));

   // trigger memory: entry plus timing per trigger
   ttoe_ram #(.DEPTH(NUM_TRIGGERS), .WIDTH(WW), .AW(TIW)) u_trig_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (a_raddr),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_data (a_rdata)
   );

   // reading memory
   ttoe_ram #(.DEPTH(NUM_READINGS), .WIDTH(16), .AW(RIW)) u_read_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (b_raddr),
      .wr_en   (b_we),
      .wr_addr (req_data.slot[RIW-1:0]),
      .wr_data (req_data.value),
      .rd_data (b_rdata)
   );

   ttoe_eval #(.NUM_READINGS(NUM_READINGS), .NUM_OUTPUTS(NUM_OUTPUTS)) u_eval (
      .word     (word_ff),
      .reading  (rd_ff),
      .hold     (hold_ff),
      .lock     (lock_ff),
      .now_ms   (req_ff.now_ms),
      .out_cur  (out_ff),
      .act      (act),
      .out_next (out_next)
   );

   assign b_we    = accept && (req_data.cmd == ttoe_pkg::CMD_STORE) &&
                    ({1'b0, req_data.slot} < 9'(NUM_READINGS));
   assign b_raddr = a_rdata.entry.source[RIW-1:0];
   assign band32  = {{16{word_ff.entry.band[15]}}, word_ff.entry.band};

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      out_in       = out_ff;
      events_in    = events_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      a_raddr      = idx_ff;
      a_we         = 1'b0;
      a_waddr      = idx_ff;
      a_wdata      = word_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               status_in = 1'b0;
               events_in = '0;
               case (req_data.cmd)
                  ttoe_pkg::CMD_STORE: begin
                     rsp_valid_in = 1'b1;
                     status_in    = !b_we;
                  end
                  ttoe_pkg::CMD_WRITE: begin
                     a_raddr = req_data.slot[TIW-1:0];
                     if (wr_ok) begin
                        state_in = ST_WENT;
                     end else begin
                        rsp_valid_in = 1'b1;
                        status_in    = 1'b1;
                     end
                  end
                  ttoe_pkg::CMD_EVAL: begin
                     a_raddr  = '0;
                     idx_in   = '0;
                     state_in = ST_ENT;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     status_in    = 1'b1;
                     for (int j = 0; j < NUM_OUTPUTS; j++) begin
                        if (8'(j) == req_data.slot) begin
                           out_in[j] = req_data.level;
                           status_in = 1'b0;
                        end
                     end
                  end
               endcase
            end
         end
         ST_WENT: begin
            // new entry fields, timing kept as it was
            a_we                     = 1'b1;
            a_waddr                  = req_ff.slot[TIW-1:0];
            a_wdata.timing           = a_rdata.timing;
            a_wdata.entry.source     = req_ff.source_sel;
            a_wdata.entry.oper       = req_ff.oper_code;
            a_wdata.entry.out        = req_ff.out_index;
            a_wdata.entry.polarity   = req_ff.out_polarity;
            a_wdata.entry.threshold  = req_ff.value;
            a_wdata.entry.band       = req_ff.band;
            rsp_valid_in             = 1'b1;
            state_in                 = ST_IDLE;
         end
         ST_ENT: begin
            state_in = ST_SRC;
         end
         ST_SRC: begin
            state_in = ST_ACT;
         end
         ST_ACT: begin
            a_we           = 1'b1;
            a_wdata.timing = act.timing;
            out_in         = out_next;
            for (int j = 0; j < 16; j++) begin
               if ((int'(idx_ff) == j) && act.fire) begin
                  events_in[j] = 1'b1;
               end
            end
            if (idx_ff == LAST_IDX) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               a_raddr  = idx_ff + 1'b1;
               state_in = ST_ENT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         out_ff       <= '0;
         events_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         out_ff       <= out_in;
         events_ff    <= events_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   // payload and per-trigger working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_ENT) begin
         word_ff <= a_rdata;
      end
      if (state_ff == ST_SRC) begin
         rd_ff   <= b_rdata;
         hold_ff <= 32'(band32 * ttoe_pkg::HOLD_UNIT);
         lock_ff <= 32'(band32 * 32'(32'(idx_ff) * ttoe_pkg::HOLD_UNIT));
      end
   end

   assign out_wide              = 16'(out_ff);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.status       = status_ff;
   assign rsp_data.output_bits  = out_wide[4:0];
   assign rsp_data.event_mask   = events_ff;

`ifndef SYNTHESIS
   a_rsp_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while busy");

   a_store_rsp : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.cmd == ttoe_pkg::CMD_STORE)) |=> rsp_valid)
      else $error("store reading gave no result beat");

   a_walk : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ACT) && (idx_ff != LAST_IDX)) |=>
         ((state_ff == ST_ENT) && !rsp_valid))
      else $error("evaluate walk broke off early");
`endif

endmodule

>>> tb/threshold_trigger_output_engine_checker.sv
// ----------------------------------------------------------------------------
// threshold_trigger_output_engine_checker
// Watches the command and result channels, predicts each result from its own
// model of the trigger bank and compares field by field.
// ----------------------------------------------------------------------------
module threshold_trigger_output_engine_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  ttoe_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  ttoe_pkg::rsp_type rsp_data,
   output int                errors,
   output int                pending
);

   localparam int NTRIG = 16;
   localparam int NREAD = 16;
   localparam int NOUT  = 5;

   ttoe_pkg::entry_type trig_tab [NTRIG];
   logic signed [15:0]  readings [NREAD];
   logic [31:0]         on_time  [NTRIG];
   logic                is_on    [NTRIG];
   logic [4:0]          out_bits;
   ttoe_pkg::rsp_type   awaited_q [$];

   // switch trigger idx on or off; returns 1 when its event bit is set
   function automatic bit switch_trigger(int idx, bit on, logic [31:0] now);
      ttoe_pkg::entry_type e;
      logic                tgt;
      logic [31:0]         lock;
      e = trig_tab[idx];
      if (e.out >= NOUT) return 1'b1;
      tgt = on ? e.polarity : ~e.polarity;
      if (out_bits[e.out] == tgt) return 1'b0;
      lock = 32'(int'(e.band) * idx * int'(ttoe_pkg::HOLD_UNIT));
      if (!is_on[idx] && on && on_time[idx] != 0 && (now - on_time[idx]) < lock)
         return 1'b0;
      is_on[idx] = on;
      if (e.band > 0 && e.oper > ttoe_pkg::OPER_BAND) on_time[idx] = now;
      out_bits[e.out] = tgt;
      return 1'b1;
   endfunction

   function automatic logic [15:0] scan_triggers(logic [31:0] now);
      logic [15:0]         mask;
      ttoe_pkg::entry_type e;
      int                  rd, th, bd;
      logic [31:0]         el, hold, lock;
      bit                  ev;
      mask = '0;
      for (int i = 0; i < NTRIG; i++) begin
         e = trig_tab[i];
         if (e.oper == ttoe_pkg::OPER_NONE || e.oper == ttoe_pkg::OPER_OFF ||
             e.source >= NREAD) continue;
         rd   = int'(readings[e.source]);
         th   = int'(e.threshold);
         bd   = int'(e.band);
         el   = now - on_time[i];
         hold = 32'(bd * int'(ttoe_pkg::HOLD_UNIT));
         lock = 32'(bd * i * int'(ttoe_pkg::HOLD_UNIT));
         ev   = 1'b0;
         if (is_on[i] && on_time[i] != 0 && el > hold)
            ev = switch_trigger(i, 1'b0, now);
         else if (e.oper == ttoe_pkg::OPER_BAND && th <= rd - bd)
            ev = switch_trigger(i, 1'b1, now);
         else if (e.oper == ttoe_pkg::OPER_BAND && th >= rd + bd)
            ev = switch_trigger(i, 1'b0, now);
         else if (e.oper == ttoe_pkg::OPER_ABOVE && th < rd)
            ev = switch_trigger(i, 1'b1, now);
         else if (e.oper == ttoe_pkg::OPER_BELOW && th > rd)
            ev = switch_trigger(i, 1'b1, now);
         else if (!is_on[i] && on_time[i] != 0 && el > lock)
            on_time[i] = '0;
         if (ev) mask[i] = 1'b1;
      end
      return mask;
   endfunction

   function automatic ttoe_pkg::rsp_type next_outputs(ttoe_pkg::req_type r);
      ttoe_pkg::rsp_type o;
      o = '0;
      case (r.cmd)
         ttoe_pkg::CMD_STORE: begin
            if (r.slot < NREAD) readings[r.slot] = r.value;
            else o.status = 1'b1;
         end
         ttoe_pkg::CMD_WRITE: begin
            if (r.slot < NTRIG && r.source_sel < NREAD) begin
               trig_tab[r.slot] = '{source: r.source_sel, oper: r.oper_code,
                                    out: r.out_index, polarity: r.out_polarity,
                                    threshold: r.value, band: r.band};
            end else o.status = 1'b1;
         end
         ttoe_pkg::CMD_EVAL: o.event_mask = scan_triggers(r.now_ms);
         default: begin
            if (r.slot < NOUT) out_bits[r.slot] = r.level;
            else o.status = 1'b1;
         end
      endcase
      o.output_bits = out_bits;
      return o;
   endfunction

   initial begin
      errors  = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      ttoe_pkg::rsp_type exp_rsp;
      if (reset) begin
         awaited_q.delete();
         foreach (trig_tab[i]) begin
            trig_tab[i] = '0;
            on_time[i]  = '0;
            is_on[i]    = 1'b0;
         end
         foreach (readings[i]) readings[i] = '0;
         out_bits = '0;
      end else begin
         // result beat first: it always belongs to an earlier command
         if (rsp_valid) begin
            if (awaited_q.size() == 0) begin
               $error("result beat with nothing expected");
               errors++;
            end else begin
               exp_rsp = awaited_q.pop_front();
               if (rsp_data.status !== exp_rsp.status) begin
                  $error("status: expected %0d, got %0d", exp_rsp.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.output_bits !== exp_rsp.output_bits) begin
                  $error("output_bits: expected %h, got %h",
                         exp_rsp.output_bits, rsp_data.output_bits);
                  errors++;
               end
               if (rsp_data.event_mask !== exp_rsp.event_mask) begin
                  $error("event_mask: expected %h, got %h",
                         exp_rsp.event_mask, rsp_data.event_mask);
                  errors++;
               end
            end
         end
         if (start && !busy) awaited_q.push_back(next_outputs(req_data));
      end
      pending = awaited_q.size();
   end

endmodule

>>> tb/threshold_trigger_output_engine_top_tb.sv
// ----------------------------------------------------------------------------
// threshold_trigger_output_engine_top_tb
// Drives store, write, evaluate and force commands into the trigger engine.
// ----------------------------------------------------------------------------
// A short directed run covers field extremes, every command and operator and
// the out-of-range cases; a long random run then builds small trigger tables
// around a few readings and evaluates them with a moving millisecond clock so
// that hold times, hysteresis and the re-arm lockout all come into play. The
// checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module threshold_trigger_output_engine_top_tb;

   localparam int NUM_RANDOM = 1525;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   ttoe_pkg::req_type req_data = '0;
   logic              rsp_valid;
   ttoe_pkg::rsp_type rsp_data;
   int                errors;
   int                pending;

   logic [31:0] clock_ms = 32'd1;   // running evaluate time
   bit          gaps_on  = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   threshold_trigger_output_engine_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   threshold_trigger_output_engine_checker scoreboard (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .errors    (errors),
      .pending   (pending)
   );

   // one command beat: random idle cycles, then hold start until busy is low
   task automatic issue(ttoe_pkg::req_type r);
      while (gaps_on && $urandom_range(99) < 28) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   function automatic ttoe_pkg::req_type cmd_beat(logic [1:0] c, logic [7:0] s);
      ttoe_pkg::req_type r;
      r        = ttoe_pkg::req_type'({$urandom, $urandom, $urandom, $urandom});
      r.cmd    = c;
      r.slot   = s;
      r.now_ms = clock_ms;
      return r;
   endfunction

   // random command, mostly well-formed, with content near the interesting boundaries
   function automatic ttoe_pkg::req_type random_cmd();
      ttoe_pkg::req_type r;
      int                pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         // noise: every field fully random
         r = ttoe_pkg::req_type'({$urandom, $urandom, $urandom, $urandom});
      end else if (pick < 30) begin
         r       = cmd_beat(ttoe_pkg::CMD_STORE, 8'($urandom_range(15)));
         r.value = 16'($signed($urandom_range(60)) - 30);
         if ($urandom_range(19) == 0) r.value = 16'($urandom);
      end else if (pick < 50) begin
         r              = cmd_beat(ttoe_pkg::CMD_WRITE, 8'($urandom_range(15)));
         r.source_sel   = 8'($urandom_range(3));
         r.oper_code    = 8'($urandom_range(3));
         r.out_index    = 8'($urandom_range(5));
         r.value        = 16'($signed($urandom_range(40)) - 20);
         r.band         = 16'($signed($urandom_range(25)) - 3);
         if ($urandom_range(9) == 0) r.oper_code = 8'($urandom);
         if ($urandom_range(9) == 0) r.band = 16'($urandom);
      end else if (pick < 88) begin
         // time mostly creeps forward, now and then jumps or hits zero
         case ($urandom_range(9))
            0:       clock_ms = $urandom;
            1:       clock_ms = '0;
            default: clock_ms = clock_ms + $urandom_range(2500);
         endcase
         r = cmd_beat(ttoe_pkg::CMD_EVAL, 8'($urandom));
      end else begin
         r = cmd_beat(ttoe_pkg::CMD_FORCE, 8'($urandom_range(5)));
      end
      return r;
   endfunction

   initial begin
      ttoe_pkg::req_type r;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes and out-of-range slots
      r = cmd_beat(ttoe_pkg::CMD_STORE, 8'd0);   r.value = 16'sh7fff; issue(r);
      r = cmd_beat(ttoe_pkg::CMD_STORE, 8'd15);  r.value = 16'sh8000; issue(r);
      r = cmd_beat(ttoe_pkg::CMD_STORE, 8'd16);  issue(r);
      r = cmd_beat(ttoe_pkg::CMD_STORE, 8'd255); issue(r);
      r = cmd_beat(ttoe_pkg::CMD_WRITE, 8'd16);  r.source_sel = 8'd0; issue(r);
      r = cmd_beat(ttoe_pkg::CMD_WRITE, 8'd0);   r.source_sel = 8'd16; issue(r);
      r = cmd_beat(ttoe_pkg::CMD_WRITE, 8'd0);   r.source_sel = 8'd255; issue(r);
      // greater with a hold time, on output 0
      r = cmd_beat(ttoe_pkg::CMD_WRITE, 8'd1);   r.source_sel = 8'd0;
      r.oper_code = ttoe_pkg::OPER_ABOVE;
      r.out_index = 8'd0; r.out_polarity = 1'b1; r.value = 16'sd5; r.band = 16'sd2;
      issue(r);
      // less on output 4, active low
      r = cmd_beat(ttoe_pkg::CMD_WRITE, 8'd2);   r.source_sel = 8'd15;
      r.oper_code = ttoe_pkg::OPER_BELOW;
      r.out_index = 8'd4; r.out_polarity = 1'b0; r.value = 16'sd0; r.band = 16'sd1;
      issue(r);
      // equal band, event-only output
      r = cmd_beat(ttoe_pkg::CMD_WRITE, 8'd15);  r.source_sel = 8'd0;
      r.oper_code = ttoe_pkg::OPER_BAND;
      r.out_index = 8'd255; r.value = 16'sh8000; r.band = 16'sh7fff; issue(r);
      r = cmd_beat(ttoe_pkg::CMD_WRITE, 8'd3);   r.source_sel = 8'd0;
      r.oper_code = ttoe_pkg::OPER_OFF; issue(r);
      r = cmd_beat(ttoe_pkg::CMD_WRITE, 8'd4);   r.source_sel = 8'd0; r.oper_code = 8'd7;
      r.out_index = 8'd5; issue(r);
      r = cmd_beat(ttoe_pkg::CMD_WRITE, 8'd5);   r.source_sel = 8'd0;
      r.oper_code = ttoe_pkg::OPER_NONE; issue(r);
      // switch at time zero, then after hold and past lockout
      clock_ms = '0;            r = cmd_beat(ttoe_pkg::CMD_EVAL, 8'd0); issue(r);
      clock_ms = 32'd100;       r = cmd_beat(ttoe_pkg::CMD_EVAL, 8'd0); issue(r);
      clock_ms = 32'd1000;      r = cmd_beat(ttoe_pkg::CMD_EVAL, 8'hff); issue(r);
      clock_ms = 32'hffff_ffff; r = cmd_beat(ttoe_pkg::CMD_EVAL, 8'd0); issue(r);
      for (int k = 0; k < 5; k++) begin
         r = cmd_beat(ttoe_pkg::CMD_FORCE, 8'(k)); r.level = k[0]; issue(r);
      end
      r = cmd_beat(ttoe_pkg::CMD_FORCE, 8'd5);   issue(r);
      r = cmd_beat(ttoe_pkg::CMD_FORCE, 8'd255); issue(r);
      clock_ms = 32'd5000;      r = cmd_beat(ttoe_pkg::CMD_EVAL, 8'd0); issue(r);

      // random phase, with a stretch of back-to-back beats in the middle
      for (int n = 0; n < NUM_RANDOM; n++) begin
         gaps_on = !(n >= 600 && n < 900);
         issue(random_cmd());
      end
      @(negedge clock);
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
